[rtl/confusion_matrix_accumulator_core_defines.svh]
// Assertion macros shared by the confusion matrix accumulator RTL.
`ifndef CONFUSION_MATRIX_ACCUMULATOR_CORE_DEFINES_SVH
`define CONFUSION_MATRIX_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define CMAC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on clk and switched off during rst.
`define CMAC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[rtl/cmac_pkg.sv]
// Shared types and constants of the confusion matrix accumulator.
`timescale 1ns / 1ps
`default_nettype none

package cmac_pkg;

  localparam int MAX_CLASSES_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int RESULT_W        = 32;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic [1:0] ACT_PAIR  = 2'd0;
  localparam logic [1:0] ACT_SCORE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic REG_NUM_CLASSES = 1'b0;
  localparam logic REG_SCORE_CUT   = 1'b1;

  localparam logic [4:0]         NUM_CLASSES_RST = 5'd2;
  localparam logic signed [15:0] SCORE_CUT_RST   = 16'sd8192;

  typedef struct packed {
    logic [4:0]         num_classes;
    logic signed [15:0] score_cut;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/cmac_cfg.sv]
// APB configuration registers of the confusion matrix accumulator.
`timescale 1ns / 1ps
`default_nettype none

module cmac_cfg (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [cmac_pkg::PADDR_W-1:0]      paddr,
  input  wire [cmac_pkg::PDATA_W-1:0]      pwdata,
  output logic [cmac_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  output cmac_pkg::cfg_t                   cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_classes <= cmac_pkg::NUM_CLASSES_RST;
      cfg.score_cut   <= cmac_pkg::SCORE_CUT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        cmac_pkg::REG_NUM_CLASSES: cfg.num_classes <= pwdata[4:0];
        cmac_pkg::REG_SCORE_CUT:   cfg.score_cut   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      cmac_pkg::REG_NUM_CLASSES: prdata = {27'd0, cfg.num_classes};
      cmac_pkg::REG_SCORE_CUT:   prdata = {16'd0, cfg.score_cut};
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/cmac_cell_ram.sv]
// Cell count memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cmac_cell_ram #(
  parameter int DEPTH = cmac_pkg::MAX_CLASSES_DEF * cmac_pkg::MAX_CLASSES_DEF,
  parameter int DW    = cmac_pkg::COUNT_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire            clk,
  input  wire            we,
  input  wire [AW-1:0]   waddr,
  input  wire [DW-1:0]   wdata,
  input  wire [AW-1:0]   raddr,
  output logic [DW-1:0]  rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/cmac_sum_ram.sv]
// Row and column total memory: one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module cmac_sum_ram #(
  parameter int DEPTH = 2 * cmac_pkg::MAX_CLASSES_DEF,
  parameter int DW    = cmac_pkg::COUNT_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire            clk,
  input  wire            we,
  input  wire [AW-1:0]   waddr,
  input  wire [DW-1:0]   wdata,
  input  wire [AW-1:0]   raddr_a,
  input  wire [AW-1:0]   raddr_b,
  output logic [DW-1:0]  rdata_a,
  output logic [DW-1:0]  rdata_b
);

  // Rows occupy the lower half, columns the upper half.
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[rtl/confusion_matrix_accumulator_core.sv]
// Top level of the confusion matrix accumulator with its update sequencer.
// A rejected item is answered in the cycle after acceptance, straight from the idle state;
// a read passes through the update state; a record passes through the update state and then
// the column write state, set by the single write port of the totals memory. A clear writes
// zero to every cell; after rst such a clearing pass holds busy high.
`timescale 1ns / 1ps
`default_nettype none

`include "confusion_matrix_accumulator_core_defines.svh"

module confusion_matrix_accumulator_core #(
  parameter int MAX_CLASSES = cmac_pkg::MAX_CLASSES_DEF,
  parameter int COUNT_WIDTH = cmac_pkg::COUNT_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  output logic                                busy,
  input  wire [1:0]                           action,
  input  wire [3:0]                           actual_class,
  input  wire [3:0]                           predicted_class,
  input  wire signed [15:0]                   score,
  output logic                                done,
  output logic                                status,
  output logic [cmac_pkg::RESULT_W-1:0]       cell_count,
  output logic [cmac_pkg::RESULT_W-1:0]       row_total,
  output logic [cmac_pkg::RESULT_W-1:0]       col_total,
  output logic [cmac_pkg::RESULT_W-1:0]       grand_total,
  output logic [cmac_pkg::RESULT_W-1:0]       correct_total,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire [cmac_pkg::PADDR_W-1:0]         paddr,
  input  wire [cmac_pkg::PDATA_W-1:0]         pwdata,
  output logic [cmac_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  localparam int CELL_DEPTH = MAX_CLASSES * MAX_CLASSES;
  localparam int CELL_AW    = $clog2(CELL_DEPTH);
  localparam int SUM_DEPTH  = 2 * MAX_CLASSES;
  localparam int SUM_AW     = $clog2(SUM_DEPTH);
  localparam int LIM_W      = ($clog2(MAX_CLASSES + 1) > 5) ? $clog2(MAX_CLASSES + 1) : 5;
  localparam int RW         = cmac_pkg::RESULT_W;
  localparam logic [CELL_AW-1:0] CELL_LAST = CELL_AW'(CELL_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CLEAR  = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_COLWR  = 4'b1000
  } state_t;

  cmac_pkg::cfg_t cfg;

  state_t                 state;
  logic [CELL_AW-1:0]     clr_cnt;
  logic                   clr_report;
  logic [1:0]             act_q;
  logic                   diag_q;
  logic [CELL_AW-1:0]     cell_addr_q;
  logic [SUM_AW-1:0]      row_addr_q;
  logic [SUM_AW-1:0]      col_addr_q;
  logic [COUNT_WIDTH-1:0] col_hold;
  logic [COUNT_WIDTH-1:0] all_sum;
  logic [COUNT_WIDTH-1:0] diag_sum;

  logic [LIM_W-1:0]       nc_ext;
  logic [LIM_W-1:0]       lim;
  logic                   score_hit;
  logic [3:0]             pred_eff;
  logic                   in_bad;
  logic                   accept;
  logic [CELL_AW-1:0]     cell_raddr;
  logic [SUM_AW-1:0]      row_raddr;
  logic [SUM_AW-1:0]      col_raddr;

  logic                   inc;
  logic [COUNT_WIDTH-1:0] cell_rd, row_rd, col_rd;
  logic [COUNT_WIDTH-1:0] cell_new, row_new, col_new, all_new, diag_new;

  logic                   cell_we;
  logic [CELL_AW-1:0]     cell_waddr;
  logic [COUNT_WIDTH-1:0] cell_wdata;
  logic                   sum_we;
  logic [SUM_AW-1:0]      sum_waddr;
  logic [COUNT_WIDTH-1:0] sum_wdata;

  logic                   done_next;
  logic                   status_next;
  logic [RW-1:0]          cell_next, row_next, col_next, grand_next, correct_next;

  cmac_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Class count clamped to the range the store can hold.
  assign nc_ext = LIM_W'(cfg.num_classes);
  always_comb begin
    lim = nc_ext;
    if (nc_ext < LIM_W'(2)) begin
      lim = LIM_W'(2);
    end else if (nc_ext > LIM_W'(MAX_CLASSES)) begin
      lim = LIM_W'(MAX_CLASSES);
    end
  end

  assign score_hit = ($signed(score) >= $signed(cfg.score_cut));
  assign pred_eff  = (action == cmac_pkg::ACT_SCORE) ? {3'd0, score_hit} : predicted_class;

  // In binary mode the predicted class is 0 or 1 and always lies below the class count.
  assign in_bad = (action == cmac_pkg::ACT_SCORE) ? (actual_class >= 4'd2)
                : ((LIM_W'(actual_class) >= lim) || (LIM_W'(predicted_class) >= lim));

  assign busy   = rst || (state != ST_IDLE);
  assign accept = start && !busy;

  // The memories are addressed straight from the incoming word, so their data
  // is ready in the cycle after acceptance.
  assign cell_raddr = CELL_AW'(int'(actual_class) * MAX_CLASSES + int'(pred_eff));
  assign row_raddr  = SUM_AW'(actual_class);
  assign col_raddr  = SUM_AW'(MAX_CLASSES + int'(pred_eff));

  cmac_cell_ram #(
    .DEPTH (CELL_DEPTH),
    .DW    (COUNT_WIDTH),
    .AW    (CELL_AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rd)
  );

  cmac_sum_ram #(
    .DEPTH (SUM_DEPTH),
    .DW    (COUNT_WIDTH),
    .AW    (SUM_AW)
  ) u_sum_ram (
    .clk     (clk),
    .we      (sum_we),
    .waddr   (sum_waddr),
    .wdata   (sum_wdata),
    .raddr_a (row_raddr),
    .raddr_b (col_raddr),
    .rdata_a (row_rd),
    .rdata_b (col_rd)
  );

  assign inc      = (act_q == cmac_pkg::ACT_PAIR) || (act_q == cmac_pkg::ACT_SCORE);
  assign cell_new = cell_rd + COUNT_WIDTH'(inc);
  assign row_new  = row_rd + COUNT_WIDTH'(inc);
  assign col_new  = col_rd + COUNT_WIDTH'(inc);
  assign all_new  = all_sum + COUNT_WIDTH'(inc);
  assign diag_new = diag_sum + COUNT_WIDTH'(inc && diag_q);

  // Memory write ports. The column total goes back in the cycle after the row
  // total; busy stays high until it has landed, so no later read can miss it.
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = cell_addr_q;
    cell_wdata = cell_new;
    sum_we     = 1'b0;
    sum_waddr  = row_addr_q;
    sum_wdata  = row_new;
    unique case (state)
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_cnt;
        cell_wdata = '0;
        sum_we     = (int'(clr_cnt) < SUM_DEPTH);
        sum_waddr  = clr_cnt[SUM_AW-1:0];
        sum_wdata  = '0;
      end
      ST_UPDATE: begin
        cell_we = inc;
        sum_we  = inc;
      end
      ST_COLWR: begin
        sum_we    = 1'b1;
        sum_waddr = col_addr_q;
        sum_wdata = col_hold;
      end
      default: ;
    endcase
  end

  // Result word for this cycle's edge.
  always_comb begin
    done_next    = 1'b0;
    status_next  = 1'b0;
    cell_next    = '0;
    row_next     = '0;
    col_next     = '0;
    grand_next   = '0;
    correct_next = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && action != cmac_pkg::ACT_CLEAR && in_bad) begin
          done_next    = 1'b1;
          status_next  = 1'b1;
          grand_next   = RW'(all_sum);
          correct_next = RW'(diag_sum);
        end
      end
      ST_CLEAR: begin
        done_next = clr_report && (clr_cnt == CELL_LAST);
      end
      ST_UPDATE: begin
        done_next    = 1'b1;
        cell_next    = RW'(cell_new);
        row_next     = RW'(row_new);
        col_next     = RW'(col_new);
        grand_next   = RW'(all_new);
        correct_next = RW'(diag_new);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      clr_report <= 1'b0;
      all_sum    <= '0;
      diag_sum   <= '0;
      done       <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (action == cmac_pkg::ACT_CLEAR) begin
              state      <= ST_CLEAR;
              clr_cnt    <= '0;
              clr_report <= 1'b1;
              all_sum    <= '0;
              diag_sum   <= '0;
            end else if (!in_bad) begin
              state <= ST_UPDATE;
            end
          end
        end
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CELL_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_UPDATE: begin
          all_sum  <= all_new;
          diag_sum <= diag_new;
          state    <= inc ? ST_COLWR : ST_IDLE;
        end
        ST_COLWR: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item and result words; these need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q       <= action;
      diag_q      <= (actual_class == pred_eff);
      cell_addr_q <= cell_raddr;
      row_addr_q  <= row_raddr;
      col_addr_q  <= col_raddr;
    end
    if (state == ST_UPDATE) begin
      col_hold <= col_new;
    end
    if (done_next) begin
      status        <= status_next;
      cell_count    <= cell_next;
      row_total     <= row_next;
      col_total     <= col_next;
      grand_total   <= grand_next;
      correct_total <= correct_next;
    end
  end

  `CMAC_ASSERT_NXT(a_accept_progress, accept && action != cmac_pkg::ACT_CLEAR, done || state == ST_UPDATE)
  `CMAC_ASSERT_NXT(a_grand_step, state == ST_UPDATE && inc, all_sum == $past(all_sum) + COUNT_WIDTH'(1))
  `CMAC_ASSERT_IMP(a_reject_zero, done && status, cell_count == '0 && row_total == '0 && col_total == '0)

endmodule

`default_nettype wire
